FILE: rtl/multiword_integer_alu_defines.svh
// assertion macros for the multiword integer alu
// used by the top level, which provides clk and rst_n
`ifndef MULTIWORD_INTEGER_ALU_DEFINES_SVH
`define MULTIWORD_INTEGER_ALU_DEFINES_SVH

// same-cycle implication check
`define MIA_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication check
`define MIA_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mia_pkg.sv
// shared types, command codes and helpers for the multiword integer alu
// no dependencies
`timescale 1ns / 1ps

package mia_pkg;

    localparam logic [2:0] CMD_LOAD_A   = 3'd0;
    localparam logic [2:0] CMD_LOAD_B   = 3'd1;
    localparam logic [2:0] CMD_ADD      = 3'd2;
    localparam logic [2:0] CMD_SUBTRACT = 3'd3;
    localparam logic [2:0] CMD_MULTIPLY = 3'd4;
    localparam logic [2:0] CMD_COMPARE  = 3'd5;

    localparam logic signed [1:0] CMP_LT = -2'sd1;
    localparam logic signed [1:0] CMP_EQ = 2'sd0;
    localparam logic signed [1:0] CMP_GT = 2'sd1;

    typedef struct packed {
        logic start;
        logic shift_a;
        logic shift_b;
        logic shift_lo;
        logic shift_acc;
    } cell_ctrl_t;

    function automatic logic [5:0] clamp_len(input logic [5:0] v, input logic [5:0] max_len);
        logic [5:0] r;
        r = v;
        if (v == 6'd0)
        begin
            r = 6'd1;
        end
        else if (v > max_len)
        begin
            r = max_len;
        end
        return r;
    endfunction

endpackage

FILE: rtl/multiword_integer_alu.sv
// Multiword unsigned integer alu on 32-bit words, built as a row of WORDS cells
// that shift toward a shared head unit holding one 32x32 multiplier. Add,
// subtract and compare walk the chain once. Multiply runs WORDS rows, each a
// pass of one multiply-accumulate per cycle followed by a shift step.
// Arithmetic results then take a scan to find the normalized length before
// streaming one word per cycle while out_ready is high. Compare gives a
// single item holding its outcome.
// depends on mia_pkg, mia_cell and multiword_integer_alu_defines.svh
`timescale 1ns / 1ps
`include "multiword_integer_alu_defines.svh"

module multiword_integer_alu #(
    parameter int WORDS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        command,
    input  logic [4:0]        word_index,
    input  logic [31:0]       word_value,
    input  logic [5:0]        a_words,
    input  logic [5:0]        b_words,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       result_data,
    output logic [5:0]        result_index,
    output logic              last,
    output logic              borrow_out,
    output logic signed [1:0] compare_result,
    output logic [6:0]        result_length
);

    localparam int CW = $clog2(2 * WORDS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL_ROW, S_MUL_SHIFT, S_ADD, S_SUB, S_CMP, S_SCAN, S_OUT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] cnt_reg, row_reg, len_reg, n_reg;
    logic [31:0] carry_reg;
    logic borrow_reg;
    logic signed [1:0] cmp_reg;
    logic out_valid_reg;
    logic [31:0] word_out_reg;
    logic [5:0] index_out_reg;
    logic last_out_reg, borrow_out_reg;
    logic signed [1:0] cmp_out_reg;
    logic [6:0] length_out_reg;

    logic [31:0] a_ch [WORDS+1];
    logic [31:0] b_ch [WORDS+1];
    logic [31:0] lo_ch [WORDS+1];
    logic [31:0] acc_ch [WORDS+1];

    mia_pkg::cell_ctrl_t ctrl;
    logic set_acc;
    logic [31:0] acc_value;
    logic in_fire, is_compute, load_go, last_step;
    logic [5:0] la, lb;
    logic [63:0] mac;
    logic [32:0] sum, diff;
    logic [31:0] a_head, b_head, lo_head, acc_head, scan_word;
    logic [31:0] lo_tail, acc_tail;
    logic [CW-1:0] cnt_inc;

    assign a_head   = a_ch[0];
    assign b_head   = b_ch[0];
    assign lo_head  = lo_ch[0];
    assign acc_head = acc_ch[0];

    // tail inputs of the chains
    assign a_ch[WORDS]   = 32'd0;
    assign b_ch[WORDS]   = b_head;
    assign lo_ch[WORDS]  = lo_tail;
    assign acc_ch[WORDS] = acc_tail;

    assign in_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_fire    = in_valid && in_ready;
    assign is_compute = (command == mia_pkg::CMD_ADD) || (command == mia_pkg::CMD_SUBTRACT)
                     || (command == mia_pkg::CMD_MULTIPLY) || (command == mia_pkg::CMD_COMPARE);
    assign la = mia_pkg::clamp_len(a_words, 6'(WORDS));
    assign lb = mia_pkg::clamp_len(b_words, 6'(WORDS));

    assign mac  = 64'(a_head) * 64'(b_head) + 64'(carry_reg) + 64'(acc_head);
    assign sum  = 33'(a_head) + 33'(b_head) + 33'(carry_reg[0]);
    assign diff = {1'b0, a_head} - {1'b0, b_head} - 33'(borrow_reg);
    assign cnt_inc   = cnt_reg + CW'(1);
    assign last_step = (cnt_reg == CW'(WORDS - 1));
    assign scan_word = (cnt_reg < CW'(WORDS)) ? lo_head : acc_head;
    assign load_go   = (!out_valid_reg || out_ready) && (cnt_reg < len_reg);

    // chain control and tail inputs
    always_comb
    begin
        ctrl      = '0;
        set_acc   = 1'b0;
        acc_value = 32'd0;
        lo_tail   = lo_head;
        acc_tail  = acc_head;
        case (state_reg)
            S_IDLE:
            begin
                ctrl.start = in_fire && is_compute;
            end
            S_MUL_ROW:
            begin
                ctrl.shift_b   = 1'b1;
                ctrl.shift_acc = 1'b1;
                acc_tail       = mac[31:0];
            end
            S_MUL_SHIFT:
            begin
                ctrl.shift_a   = 1'b1;
                ctrl.shift_lo  = 1'b1;
                ctrl.shift_acc = 1'b1;
                lo_tail        = acc_head;
                acc_tail       = carry_reg;
            end
            S_ADD:
            begin
                ctrl.shift_a  = 1'b1;
                ctrl.shift_b  = 1'b1;
                ctrl.shift_lo = 1'b1;
                lo_tail       = sum[31:0];
                set_acc       = last_step;
                acc_value     = {31'd0, sum[32]};
            end
            S_SUB:
            begin
                ctrl.shift_a  = 1'b1;
                ctrl.shift_b  = 1'b1;
                ctrl.shift_lo = 1'b1;
                lo_tail       = (cnt_reg < n_reg) ? diff[31:0] : 32'd0;
            end
            S_CMP:
            begin
                ctrl.shift_a = 1'b1;
                ctrl.shift_b = 1'b1;
            end
            S_SCAN:
            begin
                ctrl.shift_lo  = (cnt_reg < CW'(WORDS));
                ctrl.shift_acc = !(cnt_reg < CW'(WORDS));
            end
            S_OUT:
            begin
                ctrl.shift_lo  = load_go && (cnt_reg < CW'(WORDS));
                ctrl.shift_acc = load_go && !(cnt_reg < CW'(WORDS));
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    for (genvar i = 0; i < WORDS; i++)
    begin : g_cell
        mia_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .sel_a      (in_fire && (command == mia_pkg::CMD_LOAD_A) && (word_index == 5'(i))),
            .sel_b      (in_fire && (command == mia_pkg::CMD_LOAD_B) && (word_index == 5'(i))),
            .keep_a     (6'(i) < la),
            .keep_b     (6'(i) < lb),
            .set_acc    ((i == 0) ? set_acc : 1'b0),
            .load_value (word_value),
            .acc_value  (acc_value),
            .a_in       (a_ch[i+1]),
            .b_in       (b_ch[i+1]),
            .lo_in      (lo_ch[i+1]),
            .acc_in     (acc_ch[i+1]),
            .a_out      (a_ch[i]),
            .b_out      (b_ch[i]),
            .lo_out     (lo_ch[i]),
            .acc_out    (acc_ch[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            row_reg        <= '0;
            len_reg        <= '0;
            n_reg          <= '0;
            carry_reg      <= 32'd0;
            borrow_reg     <= 1'b0;
            cmp_reg        <= mia_pkg::CMP_EQ;
            out_valid_reg  <= 1'b0;
            word_out_reg   <= 32'd0;
            index_out_reg  <= 6'd0;
            last_out_reg   <= 1'b0;
            borrow_out_reg <= 1'b0;
            cmp_out_reg    <= mia_pkg::CMP_EQ;
            length_out_reg <= 7'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && is_compute)
                    begin
                        cnt_reg    <= '0;
                        row_reg    <= '0;
                        len_reg    <= CW'(1);
                        n_reg      <= (la > lb) ? CW'(la) : CW'(lb);
                        carry_reg  <= 32'd0;
                        borrow_reg <= 1'b0;
                        cmp_reg    <= mia_pkg::CMP_EQ;
                        case (command)
                            mia_pkg::CMD_ADD:      state_reg <= S_ADD;
                            mia_pkg::CMD_SUBTRACT: state_reg <= S_SUB;
                            mia_pkg::CMD_MULTIPLY: state_reg <= S_MUL_ROW;
                            default:               state_reg <= S_CMP;
                        endcase
                    end
                end
                S_MUL_ROW:
                begin
                    carry_reg <= mac[63:32];
                    cnt_reg   <= last_step ? '0 : cnt_inc;
                    if (last_step)
                    begin
                        state_reg <= S_MUL_SHIFT;
                    end
                end
                S_MUL_SHIFT:
                begin
                    carry_reg <= 32'd0;
                    if (row_reg == CW'(WORDS - 1))
                    begin
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        row_reg   <= row_reg + CW'(1);
                        state_reg <= S_MUL_ROW;
                    end
                end
                S_ADD:
                begin
                    carry_reg <= {31'd0, sum[32]};
                    cnt_reg   <= last_step ? '0 : cnt_inc;
                    if (last_step)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SUB:
                begin
                    if (cnt_reg < n_reg)
                    begin
                        borrow_reg <= diff[32];
                    end
                    cnt_reg <= last_step ? '0 : cnt_inc;
                    if (last_step)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_CMP:
                begin
                    if (a_head != b_head)
                    begin
                        cmp_reg <= (a_head > b_head) ? mia_pkg::CMP_GT : mia_pkg::CMP_LT;
                    end
                    cnt_reg <= last_step ? '0 : cnt_inc;
                    if (last_step)
                    begin
                        out_valid_reg  <= 1'b1;
                        word_out_reg   <= 32'd0;
                        index_out_reg  <= 6'd0;
                        last_out_reg   <= 1'b1;
                        borrow_out_reg <= 1'b0;
                        length_out_reg <= 7'd0;
                        if (a_head != b_head)
                        begin
                            cmp_out_reg <= (a_head > b_head) ? mia_pkg::CMP_GT
                                                             : mia_pkg::CMP_LT;
                        end
                        else
                        begin
                            cmp_out_reg <= cmp_reg;
                        end
                        len_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_SCAN:
                begin
                    if (scan_word != 32'd0)
                    begin
                        len_reg <= cnt_inc;
                    end
                    if (cnt_reg == CW'(2 * WORDS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_inc;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        if (cnt_reg < len_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            word_out_reg   <= scan_word;
                            index_out_reg  <= 6'(cnt_reg);
                            last_out_reg   <= (cnt_inc == len_reg);
                            borrow_out_reg <= borrow_reg;
                            cmp_out_reg    <= mia_pkg::CMP_EQ;
                            length_out_reg <= 7'(len_reg);
                            cnt_reg        <= cnt_inc;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_data    = word_out_reg;
    assign result_index   = index_out_reg;
    assign last           = last_out_reg;
    assign borrow_out     = borrow_out_reg;
    assign compare_result = cmp_out_reg;
    assign result_length  = length_out_reg;

    `MIA_CHECK(a_last_index, (out_valid && last && result_length != 7'd0) |-> (7'(result_index) + 7'd1 == result_length), "last word index does not match length")
    `MIA_CHECK(a_inner_index, (out_valid && !last) |-> (7'(result_index) + 7'd1 < result_length), "word beyond normalized length")
    `MIA_CHECK(a_cmp_single, (out_valid && compare_result != mia_pkg::CMP_EQ) |-> (last && result_length == 7'd0), "compare outcome on arithmetic item")
    `MIA_CHECK_NEXT(a_cmp_latency, in_valid && in_ready && command == mia_pkg::CMD_COMPARE, !out_valid, "compare result too early")

endmodule

FILE: rtl/mia_cell.sv
// one word cell of the operand and result chains
// depends on mia_pkg
`timescale 1ns / 1ps

module mia_cell (
    input  logic              clk,
    input  mia_pkg::cell_ctrl_t ctrl,
    input  logic              sel_a,
    input  logic              sel_b,
    input  logic              keep_a,
    input  logic              keep_b,
    input  logic              set_acc,
    input  logic [31:0]       load_value,
    input  logic [31:0]       acc_value,
    input  logic [31:0]       a_in,
    input  logic [31:0]       b_in,
    input  logic [31:0]       lo_in,
    input  logic [31:0]       acc_in,
    output logic [31:0]       a_out,
    output logic [31:0]       b_out,
    output logic [31:0]       lo_out,
    output logic [31:0]       acc_out
);

    logic [31:0] a_store_reg, b_store_reg;
    logic [31:0] aw_reg, bw_reg, lo_reg, acc_reg;
    logic [31:0] aw_next, bw_next, lo_next, acc_next;

    always_comb
    begin
        aw_next  = aw_reg;
        bw_next  = bw_reg;
        lo_next  = lo_reg;
        acc_next = acc_reg;
        if (ctrl.start)
        begin
            aw_next  = keep_a ? a_store_reg : 32'd0;
            bw_next  = keep_b ? b_store_reg : 32'd0;
            acc_next = 32'd0;
        end
        else
        begin
            if (ctrl.shift_a)
            begin
                aw_next = a_in;
            end
            if (ctrl.shift_b)
            begin
                bw_next = b_in;
            end
            if (ctrl.shift_lo)
            begin
                lo_next = lo_in;
            end
            if (set_acc)
            begin
                acc_next = acc_value;
            end
            else if (ctrl.shift_acc)
            begin
                acc_next = acc_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_a)
        begin
            a_store_reg <= load_value;
        end
        if (sel_b)
        begin
            b_store_reg <= load_value;
        end
        aw_reg  <= aw_next;
        bw_reg  <= bw_next;
        lo_reg  <= lo_next;
        acc_reg <= acc_next;
    end

    assign a_out   = aw_reg;
    assign b_out   = bw_reg;
    assign lo_out  = lo_reg;
    assign acc_out = acc_reg;

endmodule
